// ----- src/u8u16_pkg.sv -----
package u8u16_pkg;

   localparam int ByteWidth = 8;
   localparam int UnitWidth = 16;
   localparam int CodeWidth = 21;
   localparam int PendWidth = 2;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [UnitWidth-1:0] unit_type;
   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [PendWidth-1:0] pend_type;

   // lead byte prefixes and masks
   localparam byte_type Lead2Mask  = 8'hE0;
   localparam byte_type Lead2Code  = 8'hC0;
   localparam byte_type Lead3Mask  = 8'hF0;
   localparam byte_type Lead3Code  = 8'hE0;
   localparam byte_type Lead4Mask  = 8'hF8;
   localparam byte_type Lead4Code  = 8'hF0;
   localparam byte_type ContMask   = 8'hC0;
   localparam byte_type ContCode   = 8'h80;
   localparam byte_type ContBits   = 8'h3F;
   localparam byte_type Lead2Bits  = 8'h1F;
   localparam byte_type Lead3Bits  = 8'h0F;
   localparam byte_type Lead4Bits  = 8'h07;

   localparam code_type SuppBase   = 21'h10000;
   localparam unit_type HighSurr   = 16'hD800;
   localparam unit_type LowSurr    = 16'hDC00;

   typedef struct packed {
      unit_type unit;
      logic     last;
   } slot_type;

endpackage

// ----- src/u8u16_if.sv -----
interface u8u16_req_if
   import u8u16_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type byte_in;
   logic     end_of_text;

   modport source (output valid, output byte_in, output end_of_text, input ready);
   modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface u8u16_rsp_if
   import u8u16_pkg::*;
();
   logic     valid;
   logic     ready;
   unit_type unit_out;
   logic     last_unit;

   modport source (output valid, output unit_out, output last_unit, input ready);
   modport sink (input valid, input unit_out, input last_unit, output ready);
endinterface

// ----- src/utf8_to_utf16_decoder_unit.sv -----
// Channel    Dir  Payload                         Handshake
// req_chan   in   byte_in[7:0], end_of_text       valid/ready
// rsp_chan   out  unit_out[15:0], last_unit       valid/ready
//
// One byte is taken per cycle; the decode sits between the sequence state
// registers and a two-entry result register. A byte that completes a code
// point at or above 0x10000 fills both entries, so the next byte waits
// while the high surrogate drains. Synchronous reset clears the
// open sequence and empties the result register. A stalled rsp_chan holds
// off req_chan once the result register cannot drain in the same cycle.
module utf8_to_utf16_decoder_unit
   import u8u16_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   u8u16_req_if.sink       req_chan,
   u8u16_rsp_if.source     rsp_chan
);

   code_type partial_ff, partial_in;
   pend_type pending_ff, pending_in;
   slot_type slot0_ff, slot0_in;
   slot_type slot1_ff, slot1_in;
   logic [1:0] cnt_ff, cnt_in;

   logic     accept;
   logic     pop;
   logic [1:0] n_emit;
   code_type emit_code;
   code_type supp;
   byte_type b;

   assign b        = req_chan.byte_in;
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_chan.ready);
   assign accept   = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = (cnt_ff != 2'd0);
   assign rsp_chan.unit_out  = slot0_ff.unit;
   assign rsp_chan.last_unit = slot0_ff.last;

   // sequence decode
   always_comb begin
      code_type shifted;
      shifted    = {partial_ff[CodeWidth-7:0], b[5:0]};
      partial_in = partial_ff;
      pending_in = pending_ff;
      emit_code  = '0;
      n_emit     = 2'd0;
      if (pending_ff != '0 && (b & ContMask) == ContCode) begin
         pending_in = pending_ff - pend_type'(1);
         if (pending_ff == pend_type'(1)) begin
            emit_code  = shifted;
            n_emit     = 2'd1;
            partial_in = '0;
         end else begin
            partial_in = shifted;
         end
      end else begin
         partial_in = '0;
         pending_in = '0;
         if (b[7] == 1'b0) begin
            emit_code = code_type'(b);
            n_emit    = 2'd1;
         end else if ((b & Lead2Mask) == Lead2Code) begin
            partial_in = code_type'(b & Lead2Bits);
            pending_in = pend_type'(1);
         end else if ((b & Lead3Mask) == Lead3Code) begin
            partial_in = code_type'(b & Lead3Bits);
            pending_in = pend_type'(2);
         end else if ((b & Lead4Mask) == Lead4Code) begin
            partial_in = code_type'(b & Lead4Bits);
            pending_in = pend_type'(3);
         end
      end
      if (req_chan.end_of_text) begin
         partial_in = '0;
         pending_in = '0;
      end
   end

   assign supp = emit_code - SuppBase;

   // result register
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         if (emit_code[CodeWidth-1:16] != '0) begin
            slot0_in.unit = HighSurr + unit_type'(supp[CodeWidth-1:10]);
            slot0_in.last = 1'b0;
            slot1_in.unit = LowSurr | unit_type'(supp[9:0]);
            slot1_in.last = 1'b1;
            cnt_in        = (n_emit != 2'd0) ? 2'd2 : 2'd0;
         end else begin
            slot0_in.unit = emit_code[UnitWidth-1:0];
            slot0_in.last = 1'b1;
            cnt_in        = n_emit;
         end
      end else if (pop) begin
         if (cnt_ff == 2'd2) begin
            slot0_in = slot1_ff;
            cnt_in   = 2'd1;
         end else begin
            cnt_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= '0;
         cnt_ff     <= 2'd0;
      end else begin
         if (accept) begin
            partial_ff <= partial_in;
            pending_ff <= pending_in;
         end
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // a new transfer only lands on a result register that is empty or drains this cycle
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("result register overwritten");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> (!slot0_ff.last && slot1_ff.last))
      else $error("surrogate pair out of order");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text) |=> (pending_ff == '0 && partial_ff == '0))
      else $error("sequence left open after end of text");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (pending_ff == '0 && cnt_ff == 2'd0))
      else $error("state not cleared by reset");

   a_drain_pair: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && pop) |=> (cnt_ff == 2'd1 && slot0_ff.last))
      else $error("low surrogate lost");

endmodule

// ----- verif/utf16_unit_checker.sv -----
`timescale 1ns / 100ps

module utf16_unit_checker
   import u8u16_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   u8u16_req_if  req_mon,
   u8u16_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    units_owed
);

   localparam int ReportLimit = 10;

   code_type partial_code;
   pend_type bytes_pending;
   slot_type expected_units [$];
   slot_type oldest_unit;
   int       fault_total;

   task automatic queue_unit(input unit_type value, input logic is_last);
      slot_type entry;
      entry          = '{unit: value, last: is_last};
      expected_units = {expected_units, entry};
   endtask

   // one unit below the supplementary base, else high then low surrogate
   task automatic push_code_point(input code_type cp);
      code_type offset;
      if (cp >= SuppBase) begin
         offset = cp - SuppBase;
         queue_unit(HighSurr + unit_type'(offset[20:10]), 1'b0);
         queue_unit(LowSurr + unit_type'(offset[9:0]), 1'b1);
      end else begin
         queue_unit(unit_type'(cp), 1'b1);
      end
   endtask

   task automatic decode_byte(input byte_type b, input logic eot);
      if (bytes_pending != 0 && (b & ContMask) == ContCode) begin
         partial_code  = (partial_code << 6) | code_type'(b & ContBits);
         bytes_pending = bytes_pending - 1'b1;
         if (bytes_pending == 0) begin
            push_code_point(partial_code);
            partial_code = '0;
         end
      end else begin
         // a non-continuation, or any byte with no open sequence, drops any open sequence and is decoded anew
         bytes_pending = '0;
         partial_code  = '0;
         if (b[7] == 1'b0) begin
            push_code_point(code_type'(b));
         end else if ((b & Lead2Mask) == Lead2Code) begin
            partial_code  = code_type'(b & Lead2Bits);
            bytes_pending = 2'd1;
         end else if ((b & Lead3Mask) == Lead3Code) begin
            partial_code  = code_type'(b & Lead3Bits);
            bytes_pending = 2'd2;
         end else if ((b & Lead4Mask) == Lead4Code) begin
            partial_code  = code_type'(b & Lead4Bits);
            bytes_pending = 2'd3;
         end
      end
      if (eot) begin
         bytes_pending = '0;
         partial_code  = '0;
      end
   endtask

   task automatic note_fault(input string what, input slot_type want,
                             input unit_type unit, input logic last);
      fault_total++;
      if (fault_total <= ReportLimit)
         $display("%0t %s: expected %h last %0b, got %h last %0b",
                  $realtime, what, want.unit, want.last, unit, last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         partial_code  = '0;
         bytes_pending = '0;
         fault_total   = 0;
         expected_units.delete();
      end else begin
         // predict first so a same-edge transfer still finds its expectation
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.byte_in, req_mon.end_of_text);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_units.size() == 0) begin
               note_fault("unexpected unit", '0, rsp_mon.unit_out, rsp_mon.last_unit);
            end else begin
               oldest_unit = expected_units.pop_front();
               if (oldest_unit.unit !== rsp_mon.unit_out ||
                   oldest_unit.last !== rsp_mon.last_unit)
                  note_fault("unit mismatch", oldest_unit, rsp_mon.unit_out,
                             rsp_mon.last_unit);
            end
         end
      end
      mismatch_count <= fault_total;
      units_owed     <= expected_units.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import u8u16_pkg::*;

   localparam int WatchdogLimit = 5000;
   localparam int DrainCycles   = 8;
   localparam int PhaseBytes    = 290;
   localparam int SendIdle [4]  = '{0, 60, 0, 38};
   localparam int RspStall [4]  = '{0, 0, 60, 38};

   logic clock;
   logic reset;
   int   mismatch_count;
   int   units_owed;
   int   bytes_sent;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   quiet_cycles;

   u8u16_req_if req_chan ();
   u8u16_rsp_if rsp_chan ();

   utf8_to_utf16_decoder_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf16_unit_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .units_owed     (units_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input byte_type value, input logic last);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_chan.valid       <= 1'b1;
      req_chan.byte_in     <= value;
      req_chan.end_of_text <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // stop sending until every expected unit has been transferred
   task automatic drain_units();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (units_owed != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // mostly well-formed sequences; some noise bytes and truncated sequences
   task automatic send_random_sequence();
      int       pick;
      int       seq_len;
      int       cont_count;
      logic     stop;
      byte_type rnd;
      byte_type lead;
      pick = $urandom_range(0, 9);
      stop = ($urandom_range(0, 15) == 0);
      rnd  = byte_type'($urandom);
      if (pick == 9) begin
         send_byte(rnd, stop);
      end else begin
         seq_len = $urandom_range(1, 4);
         case (seq_len)
            1: begin
               lead = {1'b0, rnd[6:0]};
            end
            2: begin
               lead = Lead2Code | (rnd & Lead2Bits);
            end
            3: begin
               lead = Lead3Code | (rnd & Lead3Bits);
            end
            default: begin
               lead = Lead4Code | (rnd & Lead4Bits);
            end
         endcase
         cont_count = (pick == 8 && seq_len > 1) ? $urandom_range(0, seq_len - 2)
                                                 : seq_len - 1;
         send_byte(lead, stop && cont_count == 0);
         for (int i = 0; i < cont_count; i++) begin
            rnd = byte_type'($urandom);
            send_byte(ContCode | (rnd & ContBits), stop && i == cont_count - 1);
         end
      end
   endtask

   initial begin
      logic [8:0] directed_text [$];
      int         phase_end;

      // bit 8 marks end of text
      directed_text = '{
         9'h000, 9'h07F,                   // ASCII extremes
         9'h0C2, 9'h080,                   // two-byte minimum payload
         9'h0EF, 9'h0BF, 9'h0BF,           // 0xFFFF
         9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,   // largest four-byte value
         9'h080,                           // stray continuation
         9'h0F8, 9'h0FF,                   // 11111xxx leads
         9'h0C3, 9'h041,                   // broken two-byte, new lead emits
         9'h0E2, 9'h0F0, 9'h090, 9'h080,   // broken three-byte, then 0x10000
         9'h180,                           // end of text on completing byte
         9'h0E2, 9'h182,                   // end of text mid-sequence
         9'h0AC,                           // continuation after discard
         9'h141
      };

      bytes_sent     = 0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      reset          <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.byte_in     <= '0;
      req_chan.end_of_text <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_text[i])
         send_byte(directed_text[i][7:0], directed_text[i][8]);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = SendIdle[phase];
         rsp_stall_pct = RspStall[phase];
         phase_end     = bytes_sent + PhaseBytes;
         while (bytes_sent < phase_end)
            send_random_sequence();
         if (phase == 1)
            drain_units();
      end

      drain_units();
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
